@@ rtl/stepper_phase_head_tracker_macros.svh @@
// Assertion macros for the stepper phase head tracker.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef STEPPER_PHASE_HEAD_TRACKER_MACROS_SVH
`define STEPPER_PHASE_HEAD_TRACKER_MACROS_SVH

`ifndef ASSERT_OFF

// checked on every rising edge of clk outside reset
`define SPHT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every rising edge of clk, reset included
`define SPHT_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define SPHT_ASSERT(lbl, prop, msg)
`define SPHT_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

@@ rtl/spht_pkg.sv @@
// Shared types and constants for the stepper phase head tracker.
// No dependencies.
`default_nettype none

package spht_pkg;

    localparam int unsigned PHASE_W    = 4;
    localparam int unsigned POSITION_W = 8;
    localparam int unsigned TRACK_W    = 7;
    localparam int unsigned PATTERN_W  = 5;
    localparam int unsigned PADDR_W    = 3;
    localparam int unsigned PDATA_W    = 32;

    localparam logic [POSITION_W-1:0] MAX_POSITION_RESET = 8'd69;
    // wider than any phase pattern, so the first agreed pair always reports
    localparam logic [PATTERN_W-1:0]  NO_PATTERN         = 5'h1F;

    // register word index (paddr[2])
    localparam logic REG_MAX_POSITION = 1'b0;

    typedef struct packed {
        logic [PHASE_W-1:0] phase_sample;
        logic               drive_enabled;
    } sample_t;

    typedef struct packed {
        logic [TRACK_W-1:0]    track;
        logic [POSITION_W-1:0] head_position;
    } result_t;

    // One step of the head for an agreed phase pattern.
    function automatic logic [POSITION_W-1:0] move_head(
        input logic [POSITION_W-1:0] position,
        input logic [POSITION_W-1:0] max_position,
        input logic [PHASE_W-1:0]    pattern
    );
        logic [1:0] coil;
        logic [1:0] coil_next;
        logic [1:0] coil_prev;
        logic [POSITION_W-1:0] pos_new;
        coil      = position[1:0];
        coil_next = coil + 2'd1;
        coil_prev = coil - 2'd1;
        pos_new   = position;
        if (pattern != '0 && !pattern[coil]) begin
            if (pattern[coil_next]) begin
                if (position < max_position)
                    pos_new = position + 8'd1;
            end
            else if (pattern[coil_prev]) begin
                if (position != '0)
                    pos_new = position - 8'd1;
            end
        end
        return pos_new;
    endfunction

endpackage

`default_nettype wire

@@ rtl/stepper_phase_head_tracker.sv @@
// Stepper phase head tracker: follows the half-track head position from
// sampled phase lines. Depends on spht_pkg and the assertion macro header.
//
// One request (a sample of the four phase lines and the enable line) is taken
// every clock unless sample_stall is high, which happens while a held result
// is stalled. A request passes an input register, then decode and a saturating
// position update into the result register. Samples pair up: the first of a
// pair counts only while the drive is enabled, the pair is used only when both
// agree, and a result (track and half-track position) is issued only when the
// agreed pattern changes.
// max_position sits at byte address 0 of the APB port.
`default_nettype none

`include "stepper_phase_head_tracker_macros.svh"

module stepper_phase_head_tracker (
    input  wire logic                          clk,
    input  wire logic                          rst_n,

    input  wire logic                          sample_valid,
    output      logic                          sample_stall,
    input  wire spht_pkg::sample_t             sample,

    output      logic                          result_valid,
    input  wire logic                          result_stall,
    output      spht_pkg::result_t             result,

    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [spht_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [spht_pkg::PDATA_W-1:0]  pwdata,
    output      logic [spht_pkg::PDATA_W-1:0]  prdata,
    output      logic                          pready
);
    import spht_pkg::*;

    // configuration
    logic [POSITION_W-1:0] max_position_reg;

    // input register
    logic    in_vld_reg;
    sample_t in_reg;

    // tracker state
    logic                  second_slot_reg, second_slot_next;
    logic [PHASE_W-1:0]    first_sample_reg, first_sample_next;
    logic [PATTERN_W-1:0]  last_pattern_reg, last_pattern_next;
    logic [POSITION_W-1:0] position_reg, position_next;

    // result register
    logic    result_vld_reg, result_vld_next;
    result_t result_reg, result_next;

    logic fire;
    logic emit;
    logic cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_MAX_POSITION)
                  ? {{(PDATA_W-POSITION_W){1'b0}}, max_position_reg}
                  : '0;

    // the held request moves on whenever the result register has room
    assign fire         = in_vld_reg && (!result_vld_reg || !result_stall);
    assign sample_stall = in_vld_reg && !fire;

    always_comb
    begin
        second_slot_next  = second_slot_reg;
        first_sample_next = first_sample_reg;
        last_pattern_next = last_pattern_reg;
        position_next     = position_reg;
        result_next       = result_reg;
        emit              = 1'b0;
        if (fire) begin
            if (!second_slot_reg) begin
                if (in_reg.drive_enabled) begin
                    first_sample_next = in_reg.phase_sample;
                    second_slot_next  = 1'b1;
                end
            end
            else begin
                second_slot_next = 1'b0;
                if (in_reg.phase_sample == first_sample_reg &&
                    {1'b0, in_reg.phase_sample} != last_pattern_reg) begin
                    emit              = 1'b1;
                    last_pattern_next = {1'b0, in_reg.phase_sample};
                    position_next     = move_head(position_reg, max_position_reg,
                                                  in_reg.phase_sample);
                    result_next.head_position = position_next;
                    result_next.track         = position_next[POSITION_W-1:1];
                end
            end
        end

        if (emit)
            result_vld_next = 1'b1;
        else if (!result_stall)
            result_vld_next = 1'b0;
        else
            result_vld_next = result_vld_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            max_position_reg <= MAX_POSITION_RESET;
            in_vld_reg       <= 1'b0;
            second_slot_reg  <= 1'b0;
            first_sample_reg <= '0;
            last_pattern_reg <= NO_PATTERN;
            position_reg     <= '0;
            result_vld_reg   <= 1'b0;
        end
        else begin
            if (cfg_wr && paddr[2] == REG_MAX_POSITION)
                max_position_reg <= pwdata[POSITION_W-1:0];
            if (!sample_stall)
                in_vld_reg <= sample_valid;
            second_slot_reg  <= second_slot_next;
            first_sample_reg <= first_sample_next;
            last_pattern_reg <= last_pattern_next;
            position_reg     <= position_next;
            result_vld_reg   <= result_vld_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (!sample_stall)
            in_reg <= sample;
        result_reg <= result_next;
    end

    assign result_valid = result_vld_reg;
    assign result       = result_reg;

    `SPHT_ASSERT(a_pos_one_step, (position_reg != $past(position_reg)) |-> (position_reg == POSITION_W'($past(position_reg) + 8'd1) || position_reg == POSITION_W'($past(position_reg) - 8'd1)), "head moved more than one half-track")
    `SPHT_ASSERT(a_pos_move_reports, (position_reg != $past(position_reg)) |-> result_valid, "head moved without a result")
    `SPHT_ASSERT(a_result_tracks_pos, result_valid |-> (result.head_position == position_reg && result.track == position_reg[POSITION_W-1:1]), "result out of step with head position")
    `SPHT_ASSERT(a_held_request_kept, (in_vld_reg && !fire) |=> in_vld_reg, "stalled request dropped")

endmodule

`default_nettype wire

@@ tb/stepper_phase_head_tracker_tb.sv @@
// Self-checking testbench for stepper_phase_head_tracker: phase-line requests are driven with
// random gaps, results are stalled at random, and each result is checked against a local head model.
// Depends on spht_pkg and the stepper_phase_head_tracker RTL.
`default_nettype none

module stepper_phase_head_tracker_tb;
    import spht_pkg::*;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int MAX_REPORTED  = 10;
    localparam int SETTLE_CYCLES = 8;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 sample_valid = 1'b0;
    logic                 sample_stall;
    sample_t              sample = '0;
    logic                 result_valid;
    logic                 result_stall = 1'b0;
    result_t              result;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [PADDR_W-1:0]   paddr = '0;
    logic [PDATA_W-1:0]   pwdata = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    stepper_phase_head_tracker u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #5 clk = ~clk;

    // head model state
    logic                  awaiting_second = 1'b0;
    logic [PHASE_W-1:0]    held_phase = '0;
    logic [PATTERN_W-1:0]  last_agreed = NO_PATTERN;
    logic [POSITION_W-1:0] head_pos = '0;
    logic [POSITION_W-1:0] max_pos = MAX_POSITION_RESET;

    result_t expected_heads[$];

    int cycle_count = 0;
    int errors = 0;
    int requests_sent = 0;
    int ignored_ticks = 0;
    int results_seen = 0;
    int settings_written = 0;
    int peak_pos = 0;
    bit quiet = 1'b0;
    int stall_left = 0;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("== FAIL ==");
            $finish;
        end
    end

    // mostly short gaps, a few long ones; none at all while quiet
    function automatic int gap_length();
        int r;
        r = $urandom_range(99);
        if (quiet || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(2, 1);
        if (r < 96)
            return $urandom_range(8, 3);
        return $urandom_range(50, 15);
    endfunction

    function automatic void note_error(string what);
        errors++;
        if (errors <= MAX_REPORTED)
            $display("ERROR @%0t: %s", $realtime, what);
    endfunction

    function automatic logic [POSITION_W-1:0] next_head(logic [PHASE_W-1:0] pat);
        logic [1:0] coil;
        logic [1:0] up_coil;
        logic [1:0] down_coil;
        coil      = head_pos[1:0];
        up_coil   = coil + 2'd1;
        down_coil = coil - 2'd1;
        if (pat == '0 || pat[coil])
            return head_pos;
        if (pat[up_coil])
            return (head_pos < max_pos) ? head_pos + 8'd1 : head_pos;
        if (pat[down_coil])
            return (head_pos != '0) ? head_pos - 8'd1 : head_pos;
        return head_pos;
    endfunction

    // model update for one accepted request
    function automatic void apply_sample(sample_t s);
        result_t r;
        if (!awaiting_second)
        begin
            if (s.drive_enabled)
            begin
                held_phase = s.phase_sample;
                awaiting_second = 1'b1;
            end
            return;
        end
        awaiting_second = 1'b0;
        if (s.phase_sample != held_phase || {1'b0, s.phase_sample} == last_agreed)
            return;
        last_agreed = {1'b0, s.phase_sample};
        head_pos = next_head(s.phase_sample);
        if (int'(head_pos) > peak_pos)
            peak_pos = int'(head_pos);
        r.track = head_pos[POSITION_W-1:1];
        r.head_position = head_pos;
        expected_heads.push_back(r);
    endfunction

    task automatic send_sample(input sample_t s);
        int gap;
        sample_valid <= 1'b1;
        sample <= s;
        do
            @(posedge clk);
        while (sample_stall);
        if (!awaiting_second && !s.drive_enabled)
            ignored_ticks++;
        apply_sample(s);
        requests_sent++;
        gap = gap_length();
        if (gap > 0)
        begin
            sample_valid <= 1'b0;
            sample <= sample_t'(5'($urandom_range(31)));
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_pair(input logic [PHASE_W-1:0] pat, input logic second_en);
        send_sample('{phase_sample: pat, drive_enabled: 1'b1});
        send_sample('{phase_sample: pat, drive_enabled: second_en});
    endtask

    // drop valid, drain expected results, let the pipeline empty
    task automatic settle(input int extra);
        sample_valid <= 1'b0;
        while (expected_heads.size() != 0)
            @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    task automatic write_max_position(input logic [POSITION_W-1:0] value);
        logic [PDATA_W-1:0] readback;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_MAX_POSITION, 2'b00};
        pwdata  <= {{(PDATA_W-POSITION_W){1'b0}}, value};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        max_pos = value;
        settings_written++;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        readback = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (readback[POSITION_W-1:0] !== value)
            note_error($sformatf("max_position readback exp %0d got %0d",
                                 value, readback[POSITION_W-1:0]));
    endtask

    // result check
    always @(posedge clk)
    begin
        result_t exp_r;
        if (rst_n && result_valid && !result_stall)
        begin
            results_seen++;
            if (expected_heads.size() == 0)
                note_error($sformatf("unexpected result track=%0d pos=%0d",
                                     result.track, result.head_position));
            else
            begin
                exp_r = expected_heads.pop_front();
                if (result.track !== exp_r.track)
                    note_error($sformatf("track exp %0d got %0d", exp_r.track, result.track));
                if (result.head_position !== exp_r.head_position)
                    note_error($sformatf("head_position exp %0d got %0d",
                                         exp_r.head_position, result.head_position));
            end
        end
    end

    // result stall; toggles between busy and quiet stretches
    always @(posedge clk)
    begin
        int len;
        if (cycle_count % 400 == 0)
            quiet <= ($urandom_range(3) == 0);
        if (stall_left > 0)
        begin
            result_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else
        begin
            len = gap_length();
            result_stall <= (len > 0);
            stall_left <= (len > 0) ? len - 1 : 0;
        end
    end

    // random request, mostly well-formed pairs that move the head
    function automatic sample_t pick_sample(int up_pct);
        sample_t s;
        logic [1:0] coil;
        logic [1:0] toward;
        int r;
        coil = head_pos[1:0];
        r = $urandom_range(99);
        s.drive_enabled = 1'($urandom_range(1));
        s.phase_sample = PHASE_W'($urandom_range(15));
        if (awaiting_second)
        begin
            if (r < 90)
                s.phase_sample = held_phase;
        end
        else if (r >= 8)
        begin
            s.drive_enabled = 1'b1;
            if (r >= 18)
            begin
                toward = ($urandom_range(99) < up_pct) ? coil + 2'd1 : coil - 2'd1;
                s.phase_sample = 4'b0001 << toward;
                if ($urandom_range(3) == 0)
                    s.phase_sample[coil + 2'd2] = 1'b1;
            end
        end
        return s;
    endfunction

    task automatic run_random(input int n_items, input int up_pct,
                              input logic [POSITION_W-1:0] limit);
        int counted;
        sample_t s;
        settle(SETTLE_CYCLES);
        write_max_position(limit);
        counted = 0;
        while (counted < n_items)
        begin
            s = pick_sample(up_pct);
            if (awaiting_second || s.drive_enabled)
                counted++;
            send_sample(s);
        end
    endtask

    task automatic test_first_report();
        send_pair(4'h0, 1'b1);
    endtask

    task automatic test_enable_gating();
        send_sample('{phase_sample: 4'h5, drive_enabled: 1'b0});
        send_sample('{phase_sample: 4'h2, drive_enabled: 1'b0});
        send_pair(4'h2, 1'b0);
    endtask

    task automatic test_disagree_and_repeat();
        send_sample('{phase_sample: 4'h4, drive_enabled: 1'b1});
        send_sample('{phase_sample: 4'h8, drive_enabled: 1'b1});
        send_pair(4'h4, 1'b1);
        send_pair(4'h4, 1'b1);
    endtask

    task automatic test_hold_and_floor();
        send_pair(4'h8, 1'b0);
        send_pair(4'hF, 1'b1);
        send_pair(4'h4, 1'b1);
        send_pair(4'h2, 1'b1);
        send_pair(4'h1, 1'b1);
        send_pair(4'h8, 1'b1);
    endtask

    task automatic test_ceiling();
        settle(SETTLE_CYCLES);
        write_max_position(8'd1);
        send_pair(4'h2, 1'b1);
        send_pair(4'h4, 1'b1);
        settle(SETTLE_CYCLES);
        // max below position: down still allowed, up never
        write_max_position(8'd0);
        send_pair(4'h1, 1'b1);
        send_pair(4'h2, 1'b1);
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_first_report();
        test_enable_gating();
        test_disagree_and_repeat();
        test_hold_and_floor();
        test_ceiling();

        run_random(700, 92, 8'd255);
        run_random(400, 50, 8'($urandom_range(254, 1)));
        run_random(350, 50, 8'd0);
        run_random(300, 30, MAX_POSITION_RESET);

        settle(20);
        if (expected_heads.size() != 0)
            note_error($sformatf("%0d results never arrived", expected_heads.size()));

        $display("Sent %0d requests (%0d ignored first ticks), checked %0d results,",
                 requests_sent, ignored_ticks, results_seen);
        $display("wrote max_position %0d times, head peaked at half-track %0d; %0d errors.",
                 settings_written, peak_pos, errors);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire
